FILE: design/blkmm_pkg.sv
// Shared sizes, op codes and front-to-back command type for the matrix multiply engine.
`timescale 1ns / 1ps
package blkmm_pkg;

  localparam int ROWS  = 16;
  localparam int INNER = 16;
  localparam int COLS  = 16;

  localparam int IDX_W = 4;
  localparam int VAL_W = 32;

  localparam int LEFT_DEPTH  = ROWS * INNER;
  localparam int RIGHT_DEPTH = INNER * COLS;
  localparam int PROD_DEPTH  = ROWS * COLS;

  localparam int LEFT_AW  = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
  localparam int RIGHT_AW = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;
  localparam int PROD_AW  = (PROD_DEPTH > 1) ? $clog2(PROD_DEPTH) : 1;
  localparam int LR_AW    = (LEFT_AW > RIGHT_AW) ? LEFT_AW : RIGHT_AW;
  localparam int CMD_AW   = (LR_AW > PROD_AW) ? LR_AW : PROD_AW;

  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int INNER_W = (INNER > 1) ? $clog2(INNER) : 1;
  localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;

  typedef enum logic [1:0] {
    OP_WR_LEFT  = 2'd0,
    OP_WR_RIGHT = 2'd1,
    OP_COMPUTE  = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef struct packed {
    op_e               kind;
    logic              ok;
    logic [CMD_AW-1:0] addr;
    logic [VAL_W-1:0]  value;
  } cmd_t;

endpackage

FILE: design/blkmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module blkmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/blkmm_front.sv
// Front end: accepts words, decodes op, checks indices, forms addresses, two-entry queue.
`timescale 1ns / 1ps
module blkmm_front import blkmm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  logic [IDX_W-1:0] row_i,
  input  logic [IDX_W-1:0] col_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_pop_i
);

  cmd_t       in_cmd;
  cmd_t       queue_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  always_comb begin
    in_cmd.kind  = op_e'(op_i);
    in_cmd.value = value_i;
    in_cmd.ok    = 1'b0;
    in_cmd.addr  = '0;
    case (in_cmd.kind)
      OP_WR_LEFT: begin
        in_cmd.ok   = (32'(row_i) < ROWS) && (32'(col_i) < INNER);
        in_cmd.addr = CMD_AW'(32'(row_i) * INNER + 32'(col_i));
      end
      OP_WR_RIGHT: begin
        in_cmd.ok   = (32'(row_i) < INNER) && (32'(col_i) < COLS);
        in_cmd.addr = CMD_AW'(32'(row_i) * COLS + 32'(col_i));
      end
      OP_READ: begin
        in_cmd.ok   = (32'(row_i) < ROWS) && (32'(col_i) < COLS);
        in_cmd.addr = CMD_AW'(32'(row_i) * COLS + 32'(col_i));
      end
      default: begin
        in_cmd.ok   = 1'b1;
        in_cmd.addr = '0;
      end
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rptr_q];

  assign wptr_d = push ? ~wptr_q : wptr_q;
  assign rptr_d = pop ? ~rptr_q : rptr_q;
  assign cnt_d  = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= in_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: design/blkmm_back.sv
// Back end: matrix stores, multiply-accumulate sequencer and output register.
`timescale 1ns / 1ps
module blkmm_back import blkmm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] read_value_o,
  output logic             done_res_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic               out_valid_q, out_valid_d;
  logic [VAL_W-1:0]   out_value_q, out_value_d;
  logic               out_done_q, out_done_d;
  logic               rd_pend_q, rd_pend_d;
  logic               rd_ok_q, rd_ok_d;
  logic               prod_valid_q, prod_valid_d;
  logic               out_free, issue;

  logic               busy_q, busy_d;
  logic [ROW_W-1:0]   r_q, r_d;
  logic [COL_W-1:0]   c_q, c_d;
  logic [INNER_W-1:0] k_q, k_d;
  logic               k_last, c_last, r_last;

  logic               v1_q, v2_q;
  logic               first1_q, last1_q, first2_q, last2_q;
  logic [PROD_AW-1:0] paddr1_q, paddr2_q;
  logic [VAL_W-1:0]   mul_q, mul, acc_q, sum;

  logic [VAL_W-1:0]   l_rdata, r_rdata, p_rdata;
  logic               l_we, r_we;

  // storage
  assign l_we = issue && (cmd_i.kind == OP_WR_LEFT) && cmd_i.ok;
  assign r_we = issue && (cmd_i.kind == OP_WR_RIGHT) && cmd_i.ok;

  blkmm_ram #(.WIDTH(VAL_W), .DEPTH(LEFT_DEPTH)) u_left (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (cmd_i.addr[LEFT_AW-1:0]),
    .wdata_i (cmd_i.value),
    .raddr_i (LEFT_AW'(32'(r_q) * INNER + 32'(k_q))),
    .rdata_o (l_rdata)
  );

  blkmm_ram #(.WIDTH(VAL_W), .DEPTH(RIGHT_DEPTH)) u_right (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (cmd_i.addr[RIGHT_AW-1:0]),
    .wdata_i (cmd_i.value),
    .raddr_i (RIGHT_AW'(32'(k_q) * COLS + 32'(c_q))),
    .rdata_o (r_rdata)
  );

  blkmm_ram #(.WIDTH(VAL_W), .DEPTH(PROD_DEPTH)) u_prod (
    .clk_i   (clk_i),
    .we_i    (v2_q && last2_q),
    .waddr_i (paddr2_q),
    .wdata_i (sum),
    .raddr_i (cmd_i.addr[PROD_AW-1:0]),
    .rdata_o (p_rdata)
  );

  // command issue
  assign out_free  = !out_valid_q || !out_stall_i;
  assign issue     = (state_q == ST_IDLE) && cmd_valid_i && !rd_pend_q && out_free;
  assign cmd_pop_o = issue;

  // MAC lane: issue -> RAM read -> multiply -> accumulate
  assign k_last = (k_q == INNER_W'(INNER - 1));
  assign c_last = (c_q == COL_W'(COLS - 1));
  assign r_last = (r_q == ROW_W'(ROWS - 1));
  assign mul    = l_rdata * r_rdata;
  assign sum    = first2_q ? mul_q : acc_q + mul_q;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_done_d   = out_done_q;
    rd_pend_d    = 1'b0;
    rd_ok_d      = rd_ok_q;
    prod_valid_d = prod_valid_q;
    busy_d       = busy_q;
    r_d          = r_q;
    c_d          = c_q;
    k_d          = k_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (rd_pend_q) begin
      out_valid_d = 1'b1;
      out_value_d = rd_ok_q ? p_rdata : '0;
      out_done_d  = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (issue) begin
          case (cmd_i.kind)
            OP_COMPUTE: begin
              state_d      = ST_RUN;
              busy_d       = 1'b1;
              r_d          = '0;
              c_d          = '0;
              k_d          = '0;
              prod_valid_d = 1'b1;
            end
            OP_READ: begin
              rd_pend_d = 1'b1;
              rd_ok_d   = cmd_i.ok && prod_valid_q;
            end
            default: begin
              out_valid_d = 1'b1;
              out_value_d = '0;
              out_done_d  = 1'b0;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (busy_q) begin
          k_d = k_q + INNER_W'(1);
          if (k_last) begin
            k_d = '0;
            c_d = c_q + COL_W'(1);
            if (c_last) begin
              c_d = '0;
              r_d = r_q + ROW_W'(1);
              if (r_last) begin
                busy_d = 1'b0;
              end
            end
          end
        end else if (!v1_q && !v2_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = '0;
          out_done_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_done_q  <= out_done_d;
    rd_ok_q     <= rd_ok_d;
    r_q         <= r_d;
    c_q         <= c_d;
    k_q         <= k_d;
    first1_q    <= (k_q == '0);
    last1_q     <= k_last;
    paddr1_q    <= PROD_AW'(32'(r_q) * COLS + 32'(c_q));
    first2_q    <= first1_q;
    last2_q     <= last1_q;
    paddr2_q    <= paddr1_q;
    mul_q       <= mul;
    if (v2_q) begin
      acc_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      rd_pend_q    <= 1'b0;
      prod_valid_q <= 1'b0;
      busy_q       <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      rd_pend_q    <= rd_pend_d;
      prod_valid_q <= prod_valid_d;
      busy_q       <= busy_d;
      v1_q         <= (state_q == ST_RUN) && busy_q;
      v2_q         <= v1_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign done_res_o   = out_done_q;

endmodule

FILE: design/blocked_matrix_multiply.sv
// Top level of the integer matrix multiply engine: front decoder/queue and back executor.
//
//   channel | direction | handshake               | word
//   in      | input     | in_valid_i / in_stall_o  | op_i, row_i, col_i, value_i
//   out     | output    | out_valid_o / out_stall_i| read_value_o, done_res_o
//
// Left/right writes retire one per cycle while idle and out_stall_i is low; product reads go
// through the registered RAM read and output register. Compute uses one multiply-accumulate
// lane fed by one left and one right read port, writing each finished product element once.
// After reset product reads return zero until the first compute has finished.
// The two-word front queue keeps taking input while the back waits on out_stall_i, until full.
`timescale 1ns / 1ps
module blocked_matrix_multiply import blkmm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  logic [IDX_W-1:0] row_i,
  input  logic [IDX_W-1:0] col_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] read_value_o,
  output logic             done_res_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  blkmm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  blkmm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .done_res_o   (done_res_o)
  );

endmodule
